@@ hdl/stt_pkg.sv @@
// Package: shared constants and types of the transposition table core.
`default_nettype none
package stt_pkg;
  localparam int unsigned TableDepth  = 65536;
  localparam int unsigned IdxW        = $clog2(TableDepth);
  localparam int unsigned ScoreOffset = 32000;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned CntW        = 17;
  localparam int unsigned MoveW       = 25;
  localparam int unsigned DataW       = 50;

  typedef enum logic [1:0] {
    REQ_PROBE = 2'd0,
    REQ_MOVE  = 2'd1,
    REQ_STORE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_ENTRY_COUNT = 2'd0,
    CFG_AGE         = 2'd1,
    CFG_MATE_THR    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BND_UPPER = 2'd0,
    BND_LOWER = 2'd1,
    BND_EXACT = 2'd2
  } bound_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_READ,
    ST_WAIT,
    ST_EVAL,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

@@ hdl/stt_mod_unit.sv @@
// Bit-serial remainder unit: key modulo entry count, one key bit per cycle.
`default_nettype none
module stt_mod_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [stt_pkg::KeyW-1:0]    key_i,
  input  wire logic [stt_pkg::CntW-1:0]    div_i,
  output logic                             done_o,
  output logic [stt_pkg::IdxW-1:0]         rem_o
);
  import stt_pkg::*;

  localparam int unsigned BitW = $clog2(KeyW + 1);

  logic [KeyW-1:0] key_q, key_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [CntW-1:0] div_q, div_d;
  logic [BitW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [CntW:0]   trial;

  always_comb begin
    key_d  = key_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[CntW-1:0], key_q[KeyW-1]};
    if (start_i) begin
      key_d  = key_i;
      rem_d  = '0;
      // clamp the modulus into 1..TableDepth
      if (div_i == '0) div_d = CntW'(1);
      else if (div_i > CntW'(TableDepth)) div_d = CntW'(TableDepth);
      else div_d = div_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one key bit, subtract once
      key_d = {key_q[KeyW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) rem_d = trial - {1'b0, div_q};
      else rem_d = trial;
      cnt_d = cnt_q + BitW'(1);
      if (cnt_q == BitW'(KeyW - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = busy_q && (cnt_q == BitW'(KeyW - 1));
  assign rem_o  = rem_d[IdxW-1:0];
endmodule
`default_nettype wire

@@ hdl/stt_entry_mem.sv @@
// Entry memory: age, data and check word per slot, one port, registered read.
`default_nettype none
module stt_entry_mem (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [stt_pkg::IdxW-1:0]     addr_i,
  input  wire logic [7:0]                   wage_i,
  input  wire logic [stt_pkg::DataW-1:0]    wdata_i,
  input  wire logic [stt_pkg::KeyW-1:0]     wcheck_i,
  output logic [7:0]                        rage_o,
  output logic [stt_pkg::DataW-1:0]         rdata_o,
  output logic [stt_pkg::KeyW-1:0]          rcheck_o
);
  import stt_pkg::*;

  localparam int unsigned EntW = 8 + DataW + KeyW;

  logic [EntW-1:0] mem_q [TableDepth];
  logic [EntW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= {wage_i, wdata_i, wcheck_i};
    rd_q <= mem_q[addr_i];
  end

  assign {rage_o, rdata_o, rcheck_o} = rd_q;
endmodule
`default_nettype wire

@@ hdl/search_transposition_table_core.sv @@
// Top level: transposition table core with serial slot index and entry memory.
`default_nettype none
// One item is taken at a time. A probe, move probe or store goes through
// latching the word, the bit-serial key modulo entry_count (one key bit per
// cycle), the registered memory read, evaluation and write-back, and the
// presentation of the result, plus the output handoff. A clear walks every
// one of the 65536 slots, one slot per cycle; the same sweep runs once after
// reset, during which no word is accepted (configuration writes are taken
// throughout). Results sit in an output register until taken, together with
// the hit and fill counts after the item; the next word is accepted while it
// waits only after the result is launched. A slot whose check word is zero
// counts as empty.
module search_transposition_table_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [63:0]                pos_key_i,
  input  wire logic [5:0]                 ply_i,
  input  wire logic [5:0]                 search_depth_i,
  input  wire logic signed [15:0]         alpha_i,
  input  wire logic signed [15:0]         beta_i,
  input  wire logic signed [15:0]         score_in_i,
  input  wire logic [1:0]                 bound_type_i,
  input  wire logic [24:0]                move_in_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [31:0]                cfg_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            key_match_o,
  output logic                            cutoff_o,
  output logic [24:0]                     move_out_o,
  output logic signed [15:0]              score_out_o,
  output logic                            written_o,
  output logic                            was_empty_o,
  output logic [31:0]                     hit_count_o,
  output logic [31:0]                     fill_count_o
);
  import stt_pkg::*;

  state_e state_q, state_d;

  // configuration registers
  logic [CntW-1:0] ecount_q;
  logic [7:0]      age_q;
  logic [14:0]     thr_q;

  // latched request
  logic [1:0]         req_q;
  logic [63:0]        key_q;
  logic [5:0]         ply_q, dep_q;
  logic signed [15:0] alpha_q, beta_q, score_q;
  logic [1:0]         bnd_q;
  logic [24:0]        move_q;
  logic [IdxW-1:0]    slot_q, slot_d;

  logic [31:0] hits_q, hits_d, fills_q, fills_d;
  logic        age_clr;

  // result held between evaluation and handoff
  logic        hold_res;
  logic        res_match_q, res_cut_q, res_wr_q, res_emp_q;
  logic [24:0] res_move_q;
  logic [15:0] res_score_q;

  // output register
  logic        ovalid_q;
  logic        o_match_q, o_cut_q, o_wr_q, o_emp_q;
  logic [24:0] o_move_q;
  logic [15:0] o_score_q;
  logic [31:0] o_hits_q, o_fills_q;
  logic        load_out;
  logic        m_match, m_cut, m_wr, m_emp;
  logic [24:0] m_move;
  logic [15:0] m_score;

  // memory port
  logic            mem_we;
  logic [IdxW-1:0] mem_addr;
  logic [7:0]      mem_wage, r_age;
  logic [DataW-1:0] mem_wdata, r_data;
  logic [63:0]     mem_wcheck, r_check;

  logic            div_start, div_done;
  logic [IdxW-1:0] rem;

  // start the divider the cycle after the word is latched
  logic div_go_q;
  logic rst_sweep_q;

  logic accept;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign div_start   = div_go_q;

  stt_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .key_i   (key_q),
    .div_i   (ecount_q),
    .done_o  (div_done),
    .rem_o   (rem)
  );

  stt_entry_mem u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .addr_i   (mem_addr),
    .wage_i   (mem_wage),
    .wdata_i  (mem_wdata),
    .wcheck_i (mem_wcheck),
    .rage_o   (r_age),
    .rdata_o  (r_data),
    .rcheck_o (r_check)
  );

  // evaluation of the read entry
  logic [5:0]         st_dep;
  logic [1:0]         st_bnd;
  logic signed [17:0] thr_s, sc_adj, sc_st, pv, pv_adj, pv_sat;
  logic               rep, is_empty;

  always_comb begin
    st_dep   = r_data[21:16];
    st_bnd   = r_data[24:23];
    thr_s    = 18'(signed'({1'b0, thr_q}));
    is_empty = (r_check == '0);
    rep      = is_empty || (r_age < age_q) || (st_dep <= dep_q);
    // store path: push mate scores away from zero, offset, saturate
    sc_adj = 18'(score_q);
    if (sc_adj > thr_s) sc_adj = sc_adj + 18'(ply_q);
    else if (sc_adj < -thr_s) sc_adj = sc_adj - 18'(ply_q);
    sc_st = sc_adj + 18'(ScoreOffset);
    if (sc_st < 0) sc_st = '0;
    if (sc_st > 18'sd65535) sc_st = 18'sd65535;
    // probe path: remove offset, pull mate scores toward zero, saturate
    pv = 18'(signed'({2'b00, r_data[15:0]})) - 18'(ScoreOffset);
    pv_adj = pv;
    if (pv > thr_s) pv_adj = pv - 18'(ply_q);
    else if (pv < -thr_s) pv_adj = pv + 18'(ply_q);
    pv_sat = pv_adj;
    if (pv_adj > 18'sd32767) pv_sat = 18'sd32767;
    if (pv_adj < -18'sd32768) pv_sat = -18'sd32768;
  end

  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    hits_d        = hits_q;
    fills_d       = fills_q;
    mem_we        = 1'b0;
    mem_addr      = slot_q;
    mem_wage      = '0;
    mem_wdata     = '0;
    mem_wcheck    = '0;
    load_out      = 1'b0;
    hold_res      = 1'b0;
    age_clr       = 1'b0;
    m_match = 1'b0; m_cut = 1'b0; m_wr = 1'b0; m_emp = 1'b0;
    m_move  = '0;   m_score = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_CLEAR) begin
            state_d = ST_CLEAR;
            slot_d  = '0;
            hits_d  = '0;
            fills_d = '0;
            age_clr = 1'b1;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_CLEAR: begin
        // zero one slot per cycle; a clear reports an all-zero word
        mem_we   = 1'b1;
        hold_res = 1'b1;
        slot_d   = slot_q + IdxW'(1);
        if (slot_q == IdxW'(TableDepth - 1)) begin
          // the sweep after reset ends without a result word
          state_d = rst_sweep_q ? ST_IDLE : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slot_d  = rem;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_WAIT;
      ST_WAIT: state_d = ST_EVAL;
      ST_EVAL: begin
        hold_res = 1'b1;
        if (req_q == REQ_STORE) begin
          if (rep) begin
            mem_we     = 1'b1;
            mem_wage   = age_q;
            mem_wdata  = {move_q, bnd_q, 1'b0, dep_q, sc_st[15:0]};
            mem_wcheck = key_q ^ {14'd0, mem_wdata};
            m_wr       = 1'b1;
          end
          if (is_empty) begin
            fills_d = fills_q + 32'd1;
            m_emp   = 1'b1;
          end
        end else if (r_check == (key_q ^ {14'd0, r_data})) begin
          m_match = 1'b1;
          m_move  = r_data[49:25];
          if (req_q == REQ_PROBE && st_dep >= dep_q) begin
            hits_d  = hits_q + 32'd1;
            m_score = pv_sat[15:0];
            // bound code three never cuts off
            unique case (st_bnd)
              BND_UPPER: begin
                if (pv_sat <= 18'(alpha_q)) begin
                  m_score = alpha_q; m_cut = 1'b1;
                end
              end
              BND_LOWER: begin
                if (pv_sat >= 18'(beta_q)) begin
                  m_score = beta_q; m_cut = 1'b1;
                end
              end
              BND_EXACT: m_cut = 1'b1;
              default: ;
            endcase
          end
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hand over once the output register is free
        if (!ovalid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rst_sweep_q <= 1'b1;
      slot_q      <= '0;
      hits_q      <= '0;
      fills_q     <= '0;
      ecount_q    <= CntW'(TableDepth);
      age_q       <= '0;
      thr_q       <= 15'd29936;
      ovalid_q    <= 1'b0;
      div_go_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      hits_q   <= hits_d;
      fills_q  <= fills_d;
      div_go_q <= accept && (req_type_i != REQ_CLEAR);
      if (state_q == ST_CLEAR && slot_q == IdxW'(TableDepth - 1)) begin
        rst_sweep_q <= 1'b0;
      end
      if (age_clr) age_q <= '0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ENTRY_COUNT: ecount_q <= cfg_data_i[CntW-1:0];
          CFG_AGE:         age_q    <= cfg_data_i[7:0];
          CFG_MATE_THR:    thr_q    <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (load_out) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      key_q   <= pos_key_i;
      ply_q   <= ply_i;
      dep_q   <= search_depth_i;
      alpha_q <= alpha_i;
      beta_q  <= beta_i;
      score_q <= score_in_i;
      bnd_q   <= bound_type_i;
      move_q  <= move_in_i;
    end
    if (hold_res) begin
      res_match_q <= m_match;
      res_cut_q   <= m_cut;
      res_move_q  <= m_move;
      res_score_q <= m_score;
      res_wr_q    <= m_wr;
      res_emp_q   <= m_emp;
    end
    if (load_out) begin
      o_match_q <= res_match_q;
      o_cut_q   <= res_cut_q;
      o_move_q  <= res_move_q;
      o_score_q <= res_score_q;
      o_wr_q    <= res_wr_q;
      o_emp_q   <= res_emp_q;
      o_hits_q  <= hits_q;
      o_fills_q <= fills_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign key_match_o  = o_match_q;
  assign cutoff_o     = o_cut_q;
  assign move_out_o   = o_move_q;
  assign score_out_o  = o_score_q;
  assign written_o    = o_wr_q;
  assign was_empty_o  = o_emp_q;
  assign hit_count_o  = o_hits_q;
  assign fill_count_o = o_fills_q;
endmodule
`default_nettype wire

@@ hdl/stt_checker.sv @@
// Port checker for the transposition table core, bound to the top level.
`default_nettype none
module stt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [24:0] move_out_o,
  input wire logic        written_o,
  input wire logic        was_empty_o,
  input wire logic        key_match_o,
  input wire logic        cutoff_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(move_out_o))
    else $error("result dropped while stalled");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");
  a_empty_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_empty_o |-> written_o)
    else $error("empty fill without write");
  a_cut_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cutoff_o |-> key_match_o)
    else $error("cutoff without key match");
endmodule

bind search_transposition_table_core stt_checker u_stt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .move_out_o  (move_out_o),
  .written_o   (written_o),
  .was_empty_o (was_empty_o),
  .key_match_o (key_match_o),
  .cutoff_o    (cutoff_o)
);
`default_nettype wire
